// ----- hw/rtl/tmr_pkg.sv -----
// ----------------------------------------------------------------------------
// tmr_pkg: shared types and codes for the trapezoid motor ramp
// Phase and operation codes, register indexes, field widths, result record.
// ----------------------------------------------------------------------------
package tmr_pkg;

    localparam int DUTY_W = 15;   // driven duty and speed registers
    localparam int ACC_W  = 17;   // signed working duty, never wraps
    localparam int CNT_W  = 16;   // cruise and profile counters
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [1:0] PH_STOP   = 2'd0;
    localparam logic [1:0] PH_ACCEL  = 2'd1;
    localparam logic [1:0] PH_CRUISE = 2'd2;
    localparam logic [1:0] PH_DECEL  = 2'd3;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_SPEED = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_INC    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECEL_DEC    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CRUISE_TICKS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DUTY     = 3'd4;

    typedef struct packed {
        logic [1:0]        phase;
        logic              drive_update;
        logic              brake_all;
        logic [DUTY_W-1:0] drive_duty;
        logic              first_motor_dir;
        logic              second_motor_dir;
        logic [CNT_W-1:0]  profiles_done;
    } t_result;

endpackage

// ----- hw/rtl/trapezoid_motor_ramp_top.sv -----
// ----------------------------------------------------------------------------
// trapezoid_motor_ramp_top: trapezoidal ramp sequencer for two drive motors
// Stop / accelerate / cruise / decelerate duty profile with turn handling.
// ----------------------------------------------------------------------------
// One result beat per input beat, one input beat per clock while the skid
// entry is empty. Ramp state and result are registered at the edge that
// accepts a beat: the result goes to the output register when that is free
// or being taken, offered from the next cycle on, else to the one-entry skid
// register behind it, which lets the block take a further beat while a result
// is stalled; the input stalls only once both output entries are full.
// Configuration writes are always ready and take effect on the next beat.
module trapezoid_motor_ramp_top
    import tmr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input beats
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_operation,
    input  logic                  i_turn_left_req,
    input  logic                  i_turn_right_req,
    input  logic                  i_travel_dir,
    // result beats
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [1:0]            o_phase,
    output logic                  o_drive_update,
    output logic                  o_brake_all,
    output logic [DUTY_W-1:0]     o_drive_duty,
    output logic                  o_first_motor_dir,
    output logic                  o_second_motor_dir,
    output logic [CNT_W-1:0]      o_profiles_done
);

    // configuration registers
    logic [DUTY_W-1:0] r_target_speed;
    logic [DUTY_W-1:0] r_accel_inc;
    logic [DUTY_W-1:0] r_decel_dec;
    logic [CNT_W-1:0]  r_cruise_ticks;
    logic [DUTY_W-1:0] r_max_duty;

    // ramp state
    logic [1:0]              r_phase, n_phase;
    logic signed [ACC_W-1:0] r_duty, n_duty;
    logic [CNT_W-1:0]        r_cruise_cnt, n_cruise_cnt;
    logic [CNT_W-1:0]        r_finished, n_finished;

    // output register and skid
    t_result r_out, r_skid, n_result;
    logic    r_out_valid, r_skid_valid;

    logic in_acc, out_take;
    logic drive, brake;
    logic signed [ACC_W-1:0] target_s, accel_s, decel_s;
    logic [CNT_W-1:0]        cnt_inc;
    logic [DUTY_W-1:0]       duty_clamped;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign in_acc      = i_in_valid && !r_skid_valid;
    assign out_take    = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_speed <= '0;
            r_accel_inc    <= DUTY_W'(1);
            r_decel_dec    <= DUTY_W'(1);
            r_cruise_ticks <= '0;
            r_max_duty     <= '1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TARGET_SPEED: r_target_speed <= i_cfg_data[DUTY_W-1:0];
                CFG_ACCEL_INC:    r_accel_inc    <= i_cfg_data[DUTY_W-1:0];
                CFG_DECEL_DEC:    r_decel_dec    <= i_cfg_data[DUTY_W-1:0];
                CFG_CRUISE_TICKS: r_cruise_ticks <= i_cfg_data[CNT_W-1:0];
                CFG_MAX_DUTY:     r_max_duty     <= i_cfg_data[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    assign target_s = $signed({2'b00, r_target_speed});
    assign accel_s  = $signed({2'b00, r_accel_inc});
    assign decel_s  = $signed({2'b00, r_decel_dec});
    assign cnt_inc  = r_cruise_cnt + CNT_W'(1);

    always_comb begin
        n_phase      = r_phase;
        n_duty       = r_duty;
        n_cruise_cnt = r_cruise_cnt;
        n_finished   = r_finished;
        drive        = 1'b0;
        brake        = 1'b0;
        unique case (i_operation)
            OP_START: n_phase = PH_ACCEL;
            OP_STOP:  n_phase = PH_STOP;
            OP_TICK: begin
                unique case (r_phase)
                    PH_STOP: begin
                        n_duty       = '0;
                        n_cruise_cnt = '0;
                        brake        = 1'b1;
                    end
                    PH_ACCEL: begin
                        if (r_duty >= target_s) begin
                            n_duty  = target_s;
                            n_phase = PH_CRUISE;
                        end else begin
                            n_duty = r_duty + accel_s;
                        end
                        drive = 1'b1;
                    end
                    PH_CRUISE: begin
                        if (cnt_inc >= r_cruise_ticks) begin
                            n_phase      = PH_DECEL;
                            n_cruise_cnt = '0;
                        end else begin
                            n_cruise_cnt = cnt_inc;
                            n_duty       = target_s;
                            drive        = 1'b1;
                        end
                    end
                    default: begin
                        if (r_duty <= 0) begin
                            n_duty     = '0;
                            n_phase    = PH_STOP;
                            n_finished = r_finished + CNT_W'(1);
                        end else begin
                            n_duty = r_duty - decel_s;
                        end
                        drive = 1'b1;
                    end
                endcase
            end
            default: ;  // unused code: no change, no drive
        endcase
    end

    always_comb begin
        if (n_duty < 0) begin
            duty_clamped = '0;
        end else if (n_duty >= $signed({2'b00, r_max_duty})) begin
            duty_clamped = r_max_duty;
        end else begin
            duty_clamped = n_duty[DUTY_W-1:0];
        end
    end

    always_comb begin
        n_result                  = '0;
        n_result.phase            = n_phase;
        n_result.drive_update     = drive;
        n_result.brake_all        = brake;
        n_result.profiles_done    = n_finished;
        if (drive) begin
            n_result.drive_duty = duty_clamped;
            // left wins over right
            if (i_turn_left_req) begin
                n_result.first_motor_dir  = 1'b0;
                n_result.second_motor_dir = 1'b1;
            end else if (i_turn_right_req) begin
                n_result.first_motor_dir  = 1'b1;
                n_result.second_motor_dir = 1'b0;
            end else begin
                n_result.first_motor_dir  = i_travel_dir;
                n_result.second_motor_dir = i_travel_dir;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_STOP;
            r_duty       <= '0;
            r_cruise_cnt <= '0;
            r_finished   <= '0;
        end else if (in_acc) begin
            r_phase      <= n_phase;
            r_duty       <= n_duty;
            r_cruise_cnt <= n_cruise_cnt;
            r_finished   <= n_finished;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // input is stalled; drain skid into output when taken
            if (out_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (in_acc) begin
            if (r_out_valid && !out_take) begin
                r_skid_valid <= 1'b1;
            end
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (in_acc) begin
            if (r_out_valid && !out_take) begin
                r_skid <= n_result;
            end else begin
                r_out <= n_result;
            end
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_phase            = r_out.phase;
    assign o_drive_update     = r_out.drive_update;
    assign o_brake_all        = r_out.brake_all;
    assign o_drive_duty       = r_out.drive_duty;
    assign o_first_motor_dir  = r_out.first_motor_dir;
    assign o_second_motor_dir = r_out.second_motor_dir;
    assign o_profiles_done    = r_out.profiles_done;

    // skid entry only ever sits behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a beat while output register is empty");

    // a braking beat reports stop phase and no drive
    a_brake_is_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.brake_all) |-> (r_out.phase == PH_STOP && !r_out.drive_update))
        else $error("brake beat with wrong phase or drive");

    // undriven beats carry zero duty and directions
    a_idle_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.drive_update) |->
            (r_out.drive_duty == '0 && !r_out.first_motor_dir && !r_out.second_motor_dir))
        else $error("undriven beat has nonzero drive fields");

    // force stop lands the phase in stop
    a_force_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_operation == OP_STOP) |=> (r_phase == PH_STOP))
        else $error("force stop did not reach stop phase");

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the trapezoid motor ramp sequencer
// Runs directed and random command beats through the ramp under a set of
// register settings, predicts every result beat in the bench and compares
// the results field by field, with random idling and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import tmr_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;   // not decoded by the block

    typedef struct packed {
        logic [1:0] op;
        logic       left;
        logic       right;
        logic       dir;
    } t_ramp_cmd;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic [1:0]            in_op = OP_TICK;
    logic                  in_left = 1'b0;
    logic                  in_right = 1'b0;
    logic                  in_dir = 1'b0;
    logic                  out_stall = 1'b0;

    logic                  o_cfg_ready;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [1:0]            o_phase;
    logic                  o_drive_update;
    logic                  o_brake_all;
    logic [DUTY_W-1:0]     o_drive_duty;
    logic                  o_first_motor_dir;
    logic                  o_second_motor_dir;
    logic [CNT_W-1:0]      o_profiles_done;

    trapezoid_motor_ramp_top dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_valid        (cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data),
        .i_in_valid         (in_valid),
        .o_in_stall         (o_in_stall),
        .i_operation        (in_op),
        .i_turn_left_req    (in_left),
        .i_turn_right_req   (in_right),
        .i_travel_dir       (in_dir),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (out_stall),
        .o_phase            (o_phase),
        .o_drive_update     (o_drive_update),
        .o_brake_all        (o_brake_all),
        .o_drive_duty       (o_drive_duty),
        .o_first_motor_dir  (o_first_motor_dir),
        .o_second_motor_dir (o_second_motor_dir),
        .o_profiles_done    (o_profiles_done)
    );

    always #1 clk = ~clk;

    // bench copy of the registers and the ramp state
    logic [DUTY_W-1:0]        cfg_target = '0;
    logic [DUTY_W-1:0]        cfg_accel  = 15'd1;
    logic [DUTY_W-1:0]        cfg_decel  = 15'd1;
    logic [CNT_W-1:0]         cfg_cruise = '0;
    logic [DUTY_W-1:0]        cfg_max    = 15'h7FFF;
    logic [1:0]               ramp_ph    = PH_STOP;
    logic signed [ACC_W-1:0]  ramp_duty  = '0;
    logic [CNT_W-1:0]         cruise_cnt = '0;
    logic [CNT_W-1:0]         finished_cnt = '0;

    t_ramp_cmd pending_beats[$];
    t_result   ramp_results_due[$];
    t_ramp_cmd next_beat;
    t_result   oldest_due;

    int  beats_queued = 0;
    int  beats_accepted = 0;
    int  results_seen = 0;
    int  mismatch_count = 0;
    int  cfg_writes = 0;
    int  settings_run = 0;
    int  in_gap = 0;
    int  out_gap = 0;
    int  hold_cycles = 0;
    bit  in_taken = 1'b0;
    bit  steady_run = 1'b0;

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady_run || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // one ramp step: updates the bench state and returns the result beat
    function automatic t_result step_ramp(input t_ramp_cmd c);
        t_result r;
        logic    drive;
        int      d;
        r = '0;
        drive = 1'b0;
        case (c.op)
            OP_START: ramp_ph = PH_ACCEL;
            OP_STOP:  ramp_ph = PH_STOP;
            OP_TICK: begin
                case (ramp_ph)
                    PH_STOP: begin
                        ramp_duty = '0;
                        cruise_cnt = '0;
                        r.brake_all = 1'b1;
                    end
                    PH_ACCEL: begin
                        if (int'(ramp_duty) >= int'(cfg_target)) begin
                            ramp_duty = $signed({2'b00, cfg_target});
                            ramp_ph = PH_CRUISE;
                        end else begin
                            ramp_duty = ramp_duty + $signed({2'b00, cfg_accel});
                        end
                        drive = 1'b1;
                    end
                    PH_CRUISE: begin
                        cruise_cnt = cruise_cnt + CNT_W'(1);
                        if (cruise_cnt >= cfg_cruise) begin
                            ramp_ph = PH_DECEL;
                            cruise_cnt = '0;
                        end else begin
                            ramp_duty = $signed({2'b00, cfg_target});
                            drive = 1'b1;
                        end
                    end
                    default: begin
                        if (int'(ramp_duty) <= 0) begin
                            ramp_duty = '0;
                            ramp_ph = PH_STOP;
                            finished_cnt = finished_cnt + CNT_W'(1);
                        end else begin
                            ramp_duty = ramp_duty - $signed({2'b00, cfg_decel});
                        end
                        drive = 1'b1;
                    end
                endcase
            end
            default: ;
        endcase
        r.phase = ramp_ph;
        r.drive_update = drive;
        if (drive) begin
            d = int'(ramp_duty);
            if (d < 0)
                r.drive_duty = '0;
            else if (d >= int'(cfg_max))
                r.drive_duty = cfg_max;
            else
                r.drive_duty = ramp_duty[DUTY_W-1:0];
            if (c.left) begin
                r.first_motor_dir = 1'b0;
                r.second_motor_dir = 1'b1;
            end else if (c.right) begin
                r.first_motor_dir = 1'b1;
                r.second_motor_dir = 1'b0;
            end else begin
                r.first_motor_dir = c.dir;
                r.second_motor_dir = c.dir;
            end
        end
        r.profiles_done = finished_cnt;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            mismatch_count++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    // input beat driver
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_taken) begin
            if (in_gap > 0) begin
                in_gap--;
                in_valid <= 1'b0;
            end else if (pending_beats.size() != 0) begin
                next_beat = pending_beats.pop_front();
                in_valid <= 1'b1;
                in_op    <= next_beat.op;
                in_left  <= next_beat.left;
                in_right <= next_beat.right;
                in_dir   <= next_beat.dir;
                in_gap = idle_len();
            end else begin
                in_valid <= 1'b0;
            end
        end
        in_taken = 1'b0;
    end

    // accepted input beats feed the predictor
    always @(posedge clk) begin
        if (rst_n && in_valid && !o_in_stall) begin
            ramp_results_due.push_back(step_ramp({in_op, in_left, in_right, in_dir}));
            beats_accepted++;
            in_taken = 1'b1;
        end
    end

    // long receiver hold-off, counted here
    always @(posedge clk) begin
        if (hold_cycles != 0)
            hold_cycles--;
    end

    always @(negedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_cycles != 0) begin
            out_stall <= 1'b1;
        end else if (out_gap != 0) begin
            out_gap--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
            out_gap = idle_len();
        end
    end

    // result monitor
    always @(posedge clk) begin
        if (rst_n && o_out_valid && !out_stall) begin
            results_seen++;
            if (ramp_results_due.size() == 0) begin
                mismatch_count++;
                $error("result beat with no prediction pending");
            end else begin
                oldest_due = ramp_results_due.pop_front();
                check_field("phase", 16'(oldest_due.phase), 16'(o_phase));
                check_field("drive_update", 16'(oldest_due.drive_update),
                            16'(o_drive_update));
                check_field("brake_all", 16'(oldest_due.brake_all), 16'(o_brake_all));
                check_field("drive_duty", 16'(oldest_due.drive_duty), 16'(o_drive_duty));
                check_field("first_motor_dir", 16'(oldest_due.first_motor_dir),
                            16'(o_first_motor_dir));
                check_field("second_motor_dir", 16'(oldest_due.second_motor_dir),
                            16'(o_second_motor_dir));
                check_field("profiles_done", oldest_due.profiles_done, o_profiles_done);
            end
        end
    end

    task automatic push_cmd(input logic [1:0] op, input logic l, input logic r,
                            input logic d);
        pending_beats.push_back('{op: op, left: l, right: r, dir: d});
        beats_queued++;
    endtask

    task automatic push_random(input logic [1:0] op);
        push_cmd(op, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
    endtask

    // start, a run of ticks, now and then a stray command in between
    task automatic push_profile();
        int n;
        int k;
        int r;
        n = $urandom_range(1, 40);
        push_random(OP_START);
        for (k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 4)
                push_random(OP_STOP);
            else if (r < 7)
                push_random(OP_UNUSED);
            else if (r < 10)
                push_random(OP_START);
            else
                push_random(OP_TICK);
        end
    endtask

    task automatic wait_idle();
        while (beats_accepted != beats_queued || ramp_results_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!o_cfg_ready);
        case (idx)
            CFG_TARGET_SPEED: cfg_target = data[DUTY_W-1:0];
            CFG_ACCEL_INC:    cfg_accel  = data[DUTY_W-1:0];
            CFG_DECEL_DEC:    cfg_decel  = data[DUTY_W-1:0];
            CFG_CRUISE_TICKS: cfg_cruise = data;
            CFG_MAX_DUTY:     cfg_max    = data[DUTY_W-1:0];
            default: ;
        endcase
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_setting(input int tgt, input int acc, input int dec,
                                input int crz, input int mx);
        wait_idle();
        write_reg(CFG_TARGET_SPEED, CFG_DATA_W'(tgt));
        write_reg(CFG_ACCEL_INC, CFG_DATA_W'(acc));
        write_reg(CFG_DECEL_DEC, CFG_DATA_W'(dec));
        write_reg(CFG_CRUISE_TICKS, CFG_DATA_W'(crz));
        write_reg(CFG_MAX_DUTY, CFG_DATA_W'(mx));
        settings_run++;
    endtask

    initial begin
        int ph;
        int first;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // reset values: zero target, so accelerate goes straight to cruise
        push_cmd(OP_TICK, 1'b1, 1'b1, 1'b1);     // stop tick brakes, no drive
        push_cmd(OP_UNUSED, 1'b1, 1'b1, 1'b1);   // ignored
        push_cmd(OP_START, 1'b1, 1'b0, 1'b1);
        push_cmd(OP_TICK, 1'b0, 1'b0, 1'b1);
        push_cmd(OP_TICK, 1'b0, 1'b1, 1'b0);     // cruise end writes nothing
        push_cmd(OP_TICK, 1'b1, 1'b1, 1'b0);     // decel at zero ends the profile
        push_cmd(OP_TICK, 1'b0, 1'b0, 1'b0);

        // widest steps, duty clamped well below the ramp
        load_setting(32767, 32767, 32767, 2, 100);
        push_cmd(OP_START, 1'b0, 1'b0, 1'b0);
        push_cmd(OP_TICK, 1'b0, 1'b1, 1'b0);
        push_cmd(OP_TICK, 1'b0, 1'b0, 1'b1);
        push_cmd(OP_TICK, 1'b1, 1'b0, 1'b1);
        push_cmd(OP_TICK, 1'b0, 1'b0, 1'b0);
        push_cmd(OP_TICK, 1'b0, 1'b1, 1'b1);
        push_cmd(OP_TICK, 1'b0, 1'b0, 1'b1);
        push_cmd(OP_STOP, 1'b1, 1'b0, 1'b0);

        // overshoot past the target, restart in cruise, forced stop
        load_setting(50, 20, 30, 3, 45);
        push_cmd(OP_START, 1'b0, 1'b0, 1'b1);
        push_cmd(OP_TICK, 1'b0, 1'b0, 1'b0);
        push_cmd(OP_TICK, 1'b1, 1'b1, 1'b1);
        push_cmd(OP_TICK, 1'b0, 1'b1, 1'b1);
        push_cmd(OP_TICK, 1'b0, 1'b0, 1'b1);
        push_cmd(OP_START, 1'b0, 1'b0, 1'b0);
        push_cmd(OP_TICK, 1'b1, 1'b0, 1'b0);
        push_cmd(OP_TICK, 1'b0, 1'b0, 1'b0);
        push_cmd(OP_STOP, 1'b0, 1'b0, 1'b0);
        push_cmd(OP_TICK, 1'b1, 1'b0, 1'b1);

        for (ph = 0; ph < 8; ph++) begin
            case (ph)
                1: load_setting(0, 0, 0, 0, 0);
                3: load_setting($urandom_range(16384, 32767), $urandom_range(8192, 32767),
                                $urandom_range(8192, 32767), $urandom_range(0, 5),
                                $urandom_range(0, 32767));
                4: load_setting(32767, 32767, 32767, 65535, 32767);
                default: load_setting($urandom_range(0, 300), $urandom_range(1, 80),
                                      $urandom_range(1, 80), $urandom_range(0, 12),
                                      $urandom_range(0, 400));
            endcase
            steady_run = (ph == 5) || ($urandom_range(0, 3) == 0);
            first = beats_queued;
            while (beats_queued - first < 100) begin
                if ($urandom_range(0, 99) < 80)
                    push_profile();
                else
                    push_random(2'($urandom_range(0, 3)));
            end
            if (ph == 2) begin
                // hold the result side while commands keep coming
                while (beats_queued - beats_accepted > 80)
                    @(negedge clk);
                hold_cycles = 150;
            end
        end

        wait_idle();
        repeat (10) @(negedge clk);
        if (ramp_results_due.size() != 0) begin
            mismatch_count++;
            $error("%0d predicted results never arrived", ramp_results_due.size());
        end
        $display("Covered %0d command beats under %0d register settings (%0d writes).",
                 beats_accepted, settings_run + 1, cfg_writes);
        $display("Checked %0d result beats; %0d profiles ran to completion.",
                 results_seen, finished_cnt);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
